// File: rtl/bgu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgu_pkg
// Shared types and constants of the bilinear grid upsampler.
// ----------------------------------------------------------------------------
package bgu_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int DIM_REG_W = 7;
  localparam int IDX_W     = 6;
  localparam int CH_W      = 3;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 3;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd1;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 7'd20;

  localparam logic [STEP_W-1:0] MAP_LAST_STEP   = 3'd5;
  localparam logic [STEP_W-1:0] BLEND_LAST_STEP = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_BLEND,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MOP_HOLD,
    MOP_PROD,
    MOP_QUOT,
    MOP_FIN
  } map_op_t;

  typedef struct packed {
    map_op_t op;
    logic    col;
  } map_ctl_t;

  typedef struct packed {
    logic mul_en;
    logic mul_hi;
    logic acc_en;
    logic acc_hi;
    logic acc_first;
  } blend_ctl_t;

endpackage
`default_nettype wire

// File: rtl/bgu_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgu_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bgu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: rtl/bgu_axis_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgu_axis_map
// Shared corner-aligned coordinate mapper, used once per axis.
// ----------------------------------------------------------------------------
module bgu_axis_map #(
  parameter int OUT_HEIGHT = 40,
  parameter int OUT_WIDTH  = 40
) (
  input  wire logic                           clk,
  input  wire bgu_pkg::map_ctl_t              ctl,
  input  wire logic [bgu_pkg::IDX_W-1:0]      row_idx,
  input  wire logic [bgu_pkg::IDX_W-1:0]      col_idx,
  input  wire logic [bgu_pkg::DIM_REG_W-1:0]  h_size,
  input  wire logic [bgu_pkg::DIM_REG_W-1:0]  w_size,
  output logic      [bgu_pkg::IDX_W-1:0]      h0,
  output logic      [bgu_pkg::IDX_W-1:0]      h1,
  output logic      [bgu_pkg::IDX_W-1:0]      w0,
  output logic      [bgu_pkg::IDX_W-1:0]      w1,
  output logic      [bgu_pkg::FRAC_W-1:0]     fh,
  output logic      [bgu_pkg::FRAC_W-1:0]     fw
);
  import bgu_pkg::*;

  localparam int PROD_W = 2 * IDX_W;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int LUT_N = 2 ** IDX_W;
  localparam logic [IDX_W-1:0] DIV_H = IDX_W'(OUT_HEIGHT - 1);
  localparam logic [IDX_W-1:0] DIV_W = IDX_W'(OUT_WIDTH - 1);
  localparam logic [RECIP_W-1:0] RECIP_H = RECIP_W'((2 ** RECIP_SHIFT) / (OUT_HEIGHT - 1));
  localparam logic [RECIP_W-1:0] RECIP_W_AX = RECIP_W'((2 ** RECIP_SHIFT) / (OUT_WIDTH - 1));

  logic [FRAC_W-1:0] lut_h [LUT_N];
  logic [FRAC_W-1:0] lut_w [LUT_N];

  for (genvar g = 0; g < LUT_N; g++) begin : g_lut
    localparam logic [FRAC_W-1:0] FH = FRAC_W'((g * 65536) / (OUT_HEIGHT - 1));
    localparam logic [FRAC_W-1:0] FW = FRAC_W'((g * 65536) / (OUT_WIDTH - 1));
    assign lut_h[g] = FH;
    assign lut_w[g] = FW;
  end

  logic [PROD_W-1:0]          prod_r, prod_nxt;
  logic [PROD_W-1:0]          quot_r, quot_nxt;
  logic [IDX_W-1:0]           h0_r, h1_r, w0_r, w1_r;
  logic [FRAC_W-1:0]          fh_r, fw_r;

  logic [IDX_W-1:0]           div_sel;
  logic [RECIP_W-1:0]         recip_sel;
  logic [IDX_W-1:0]           idx_sel;
  logic [IDX_W-1:0]           idx_clamp;
  logic [DIM_REG_W-1:0]       size_sel;
  logic [IDX_W-1:0]           size_m1;
  logic [PROD_W+RECIP_W-1:0]  quot_full;
  logic [PROD_W+IDX_W-1:0]    back_full;
  logic [PROD_W-1:0]          rem;
  logic                       fix;
  logic [PROD_W-1:0]          q_fin;
  logic [PROD_W-1:0]          b_fin;
  logic [IDX_W-1:0]           i0;
  logic [IDX_W-1:0]           i1;
  logic [FRAC_W-1:0]          frac;

  always_comb begin
    div_sel   = ctl.col ? DIV_W : DIV_H;
    recip_sel = ctl.col ? RECIP_W_AX : RECIP_H;
    idx_sel   = ctl.col ? col_idx : row_idx;
    size_sel  = ctl.col ? w_size : h_size;
    idx_clamp = (idx_sel > div_sel) ? div_sel : idx_sel;
    size_m1   = IDX_W'(size_sel - DIM_REG_W'(1));

    prod_nxt  = PROD_W'(idx_clamp) * PROD_W'(size_m1);
    quot_full = (PROD_W+RECIP_W)'(prod_r) * (PROD_W+RECIP_W)'(recip_sel);
    quot_nxt  = PROD_W'(quot_full >> RECIP_SHIFT);

    back_full = (PROD_W+IDX_W)'(quot_r) * (PROD_W+IDX_W)'(div_sel);
    rem       = prod_r - back_full[PROD_W-1:0];
    fix       = (rem >= PROD_W'(div_sel));
    q_fin     = fix ? quot_r + PROD_W'(1) : quot_r;
    b_fin     = fix ? rem - PROD_W'(div_sel) : rem;
    i0        = q_fin[IDX_W-1:0];
    frac      = ctl.col ? lut_w[b_fin[IDX_W-1:0]] : lut_h[b_fin[IDX_W-1:0]];
    i1        = ((DIM_REG_W'(i0) + DIM_REG_W'(1)) < size_sel) ? i0 + IDX_W'(1) : size_m1;
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      MOP_PROD: begin
        prod_r <= prod_nxt;
      end
      MOP_QUOT: begin
        quot_r <= quot_nxt;
      end
      MOP_FIN: begin
        if (ctl.col) begin
          w0_r <= i0;
          w1_r <= i1;
          fw_r <= frac;
        end else begin
          h0_r <= i0;
          h1_r <= i1;
          fh_r <= frac;
        end
      end
      default: begin
      end
    endcase
  end

  assign h0 = h0_r;
  assign h1 = h1_r;
  assign w0 = w0_r;
  assign w1 = w1_r;
  assign fh = fh_r;
  assign fw = fw_r;

endmodule
`default_nettype wire

// File: rtl/bgu_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgu_blend
// Shared two-step multiply-accumulate that blends the four corner samples.
// ----------------------------------------------------------------------------
module bgu_blend (
  input  wire logic                               clk,
  input  wire bgu_pkg::blend_ctl_t                ctl,
  input  wire logic signed [bgu_pkg::SAMPLE_W-1:0] rd_data,
  input  wire logic        [bgu_pkg::FRAC_W-1:0]   fh,
  input  wire logic        [bgu_pkg::FRAC_W-1:0]   fw,
  output logic signed      [bgu_pkg::SAMPLE_W-1:0] pixel
);
  import bgu_pkg::*;

  localparam int WGT_W = FRAC_W + 2;
  localparam int T_W   = SAMPLE_W + FRAC_W + 1;
  localparam int ACC_W = SAMPLE_W + 2 * FRAC_W + 1;
  localparam logic [WGT_W-1:0] ONE = WGT_W'(65536);

  logic signed [T_W-1:0]       t_r, t_nxt;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic signed [WGT_W-1:0]     wgt_row;
  logic signed [WGT_W-1:0]     wgt_col;
  logic signed [T_W+WGT_W-1:0] term;

  always_comb begin
    wgt_row = ctl.mul_hi ? signed'(WGT_W'(fh)) : signed'(ONE - WGT_W'(fh));
    wgt_col = ctl.acc_hi ? signed'(WGT_W'(fw)) : signed'(ONE - WGT_W'(fw));
    t_nxt   = T_W'(rd_data * wgt_row);
    term    = t_r * wgt_col;
    acc_nxt = (ctl.acc_first ? ACC_W'(0) : acc_r) + ACC_W'(term);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      t_r <= t_nxt;
    end
    if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  assign pixel = acc_r[2*FRAC_W +: SAMPLE_W];

endmodule
`default_nettype wire

// File: rtl/bilinear_grid_upsampler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_grid_upsampler_unit
// Loads source planes and returns corner-aligned bilinear output pixels.
// A load word gives no result and leaves the block free for the next word.
// A compute word is taken through the shared axis mapper, then the memory read
// and multiply-accumulate loop, then a register for the result. The block takes
// no new word until the result is registered; a stalled result holds it.
// Reset clears control state and sets both sizes to 20, not the sample memory.
// ----------------------------------------------------------------------------
module bilinear_grid_upsampler_unit #(
  parameter int OUT_HEIGHT     = 40,
  parameter int OUT_WIDTH      = 40,
  parameter int MAX_CHANNELS   = 8,
  parameter int MAX_SOURCE_DIM = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_mode,
  input  wire logic        [bgu_pkg::CH_W-1:0]     in_channel,
  input  wire logic        [bgu_pkg::IDX_W-1:0]    in_row,
  input  wire logic        [bgu_pkg::IDX_W-1:0]    in_col,
  input  wire logic signed [bgu_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [bgu_pkg::SAMPLE_W-1:0] out_pixel,
  input  wire logic                                cfg_write_en,
  input  wire logic        [bgu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [bgu_pkg::DIM_REG_W-1:0] cfg_data
);
  import bgu_pkg::*;

  localparam int DEPTH   = MAX_CHANNELS * MAX_SOURCE_DIM * MAX_SOURCE_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_LIM = (MAX_SOURCE_DIM < 64) ? MAX_SOURCE_DIM : 64;
  localparam logic [DIM_REG_W-1:0] DIM_MAX = DIM_REG_W'(DIM_LIM);

  state_t                    state_r, state_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [CH_W-1:0]           chan_r, chan_nxt;
  logic [IDX_W-1:0]          row_r, row_nxt;
  logic [IDX_W-1:0]          col_r, col_nxt;
  logic                      zero_r, zero_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_pixel_r, out_pixel_nxt;
  logic [DIM_REG_W-1:0]      src_height_r, src_height_nxt;
  logic [DIM_REG_W-1:0]      src_width_r, src_width_nxt;

  logic [DIM_REG_W-1:0]      h_size;
  logic [DIM_REG_W-1:0]      w_size;
  logic                      in_accept;
  logic                      chan_ok;
  logic                      pos_ok;
  logic                      out_free;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [AW-1:0]             rd_addr;
  logic [IDX_W-1:0]          rd_row;
  logic [IDX_W-1:0]          rd_col;
  map_ctl_t                  map_ctl;
  blend_ctl_t                blend_ctl;
  logic [IDX_W-1:0]          h0, h1, w0, w1;
  logic [FRAC_W-1:0]         fh, fw;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] blend_pixel;

  always_comb begin
    if (src_height_r == '0) begin
      h_size = DIM_REG_W'(1);
    end else if (src_height_r > DIM_MAX) begin
      h_size = DIM_MAX;
    end else begin
      h_size = src_height_r;
    end
    if (src_width_r == '0) begin
      w_size = DIM_REG_W'(1);
    end else if (src_width_r > DIM_MAX) begin
      w_size = DIM_MAX;
    end else begin
      w_size = src_width_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign chan_ok   = (32'(in_channel) < 32'(MAX_CHANNELS));
  assign pos_ok    = (32'(in_row) < 32'(MAX_SOURCE_DIM)) &&
                     (32'(in_col) < 32'(MAX_SOURCE_DIM));
  assign out_free  = !out_valid_r || !out_stall;

  assign wr_en   = in_accept && (in_mode == MODE_LOAD) && chan_ok && pos_ok;
  assign wr_addr = AW'((32'(in_channel) * 32'(MAX_SOURCE_DIM) + 32'(in_row)) *
                       32'(MAX_SOURCE_DIM) + 32'(in_col));
  assign rd_row  = step_r[1] ? h1 : h0;
  assign rd_col  = step_r[0] ? w1 : w0;
  assign rd_addr = AW'((32'(chan_r) * 32'(MAX_SOURCE_DIM) + 32'(rd_row)) *
                       32'(MAX_SOURCE_DIM) + 32'(rd_col));

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    chan_nxt       = chan_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    zero_nxt       = zero_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_pixel_nxt  = out_pixel_r;
    src_height_nxt = src_height_r;
    src_width_nxt  = src_width_r;
    map_ctl.op     = MOP_HOLD;
    map_ctl.col    = 1'b0;
    blend_ctl      = '0;

    if (cfg_write_en) begin
      case (cfg_index)
        CFG_SOURCE_HEIGHT: src_height_nxt = cfg_data;
        CFG_SOURCE_WIDTH:  src_width_nxt  = cfg_data;
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_mode == MODE_COMPUTE)) begin
          chan_nxt = in_channel;
          row_nxt  = in_row;
          col_nxt  = in_col;
          zero_nxt = !chan_ok;
          step_nxt = '0;
          state_nxt = chan_ok ? ST_MAP : ST_DONE;
        end
      end
      ST_MAP: begin
        map_ctl.col = (step_r >= STEP_W'(3));
        case (step_r)
          3'd0, 3'd3: map_ctl.op = MOP_PROD;
          3'd1, 3'd4: map_ctl.op = MOP_QUOT;
          3'd2, 3'd5: map_ctl.op = MOP_FIN;
          default:    map_ctl.op = MOP_HOLD;
        endcase
        if (step_r == MAP_LAST_STEP) begin
          step_nxt  = '0;
          state_nxt = ST_BLEND;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_BLEND: begin
        blend_ctl.mul_en    = (step_r >= STEP_W'(1)) && (step_r <= STEP_W'(4));
        blend_ctl.mul_hi    = (step_r >= STEP_W'(3));
        blend_ctl.acc_en    = (step_r >= STEP_W'(2));
        blend_ctl.acc_hi    = step_r[0];
        blend_ctl.acc_first = (step_r == STEP_W'(2));
        if (step_r == BLEND_LAST_STEP) begin
          step_nxt  = '0;
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pixel_nxt = zero_r ? '0 : blend_pixel;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
      src_height_r <= DIM_RESET;
      src_width_r  <= DIM_RESET;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      out_valid_r  <= out_valid_nxt;
      src_height_r <= src_height_nxt;
      src_width_r  <= src_width_nxt;
    end
    chan_r      <= chan_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    zero_r      <= zero_nxt;
    out_pixel_r <= out_pixel_nxt;
  end

  bgu_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_sample),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bgu_axis_map #(
    .OUT_HEIGHT (OUT_HEIGHT),
    .OUT_WIDTH  (OUT_WIDTH)
  ) u_map (
    .clk     (clk),
    .ctl     (map_ctl),
    .row_idx (row_r),
    .col_idx (col_r),
    .h_size  (h_size),
    .w_size  (w_size),
    .h0      (h0),
    .h1      (h1),
    .w0      (w0),
    .w1      (w1),
    .fh      (fh),
    .fw      (fw)
  );

  bgu_blend u_blend (
    .clk     (clk),
    .ctl     (blend_ctl),
    .rd_data (rd_data),
    .fh      (fh),
    .fw      (fw),
    .pixel   (blend_pixel)
  );

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule
`default_nettype wire

// File: tb/bgu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgu_checker
// Watches the load, compute and register ports of the bilinear grid
// upsampler, keeps its own copy of the source planes and sizes, predicts
// each output pixel and compares it with the result word in order.
// ----------------------------------------------------------------------------
module bgu_checker #(
  parameter int OUT_HEIGHT     = 40,
  parameter int OUT_WIDTH      = 40,
  parameter int MAX_CHANNELS   = 8,
  parameter int MAX_SOURCE_DIM = 64
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  input  logic                                     in_stall,
  input  logic                                     in_mode,
  input  logic        [bgu_pkg::CH_W-1:0]          in_channel,
  input  logic        [bgu_pkg::IDX_W-1:0]         in_row,
  input  logic        [bgu_pkg::IDX_W-1:0]         in_col,
  input  logic signed [bgu_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic                                     out_valid,
  input  logic                                     out_stall,
  input  logic signed [bgu_pkg::SAMPLE_W-1:0]      out_pixel,
  input  logic                                     cfg_write_en,
  input  logic        [bgu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic        [bgu_pkg::DIM_REG_W-1:0]     cfg_data,
  output int                                       error_count,
  output int                                       pending_results
);
  import bgu_pkg::*;

  localparam int PLANE_WORDS = MAX_CHANNELS * MAX_SOURCE_DIM * MAX_SOURCE_DIM;
  localparam int DIM_CAP     = (MAX_SOURCE_DIM < 64) ? MAX_SOURCE_DIM : 64;
  localparam longint UNIT_WEIGHT = longint'(1) << FRAC_W;

  logic signed [SAMPLE_W-1:0] plane_mem [PLANE_WORDS];
  logic [DIM_REG_W-1:0]       rows_reg;
  logic [DIM_REG_W-1:0]       cols_reg;
  logic signed [SAMPLE_W-1:0] pixel_queue [$];
  int                         mismatches = 0;
  int                         queued = 0;

  assign error_count     = mismatches;
  assign pending_results = queued;

  function automatic int clamp_dim(logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > DIM_CAP) return DIM_CAP;
    return int'(v);
  endfunction

  function automatic void grid_position(input int idx, input int out_n, input int size,
                                        output int lo, output int hi, output longint frac);
    longint pos;
    if (idx > out_n - 1) idx = out_n - 1;
    pos = (longint'(idx) * (size - 1) * UNIT_WEIGHT) / (out_n - 1);
    lo = int'(pos >> FRAC_W);
    if (lo > size - 1) lo = size - 1;
    frac = pos & (UNIT_WEIGHT - 1);
    hi = (lo + 1 < size) ? lo + 1 : size - 1;
  endfunction

  function automatic longint plane_read(int ch, int r, int c);
    int a;
    a = (ch * MAX_SOURCE_DIM + r) * MAX_SOURCE_DIM + c;
    if (a >= PLANE_WORDS) return 0;
    return longint'(plane_mem[a]);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] blend_pixel(int ch, int r, int c);
    int     h, w, r0, r1, c0, c1;
    longint fr, fc, gr, gc, acc;
    if (ch >= MAX_CHANNELS) return '0;
    h = clamp_dim(rows_reg);
    w = clamp_dim(cols_reg);
    grid_position(r, OUT_HEIGHT, h, r0, r1, fr);
    grid_position(c, OUT_WIDTH, w, c0, c1, fc);
    gr = UNIT_WEIGHT - fr;
    gc = UNIT_WEIGHT - fc;
    acc = plane_read(ch, r0, c0) * (gr * gc) + plane_read(ch, r0, c1) * (gr * fc)
        + plane_read(ch, r1, c0) * (fr * gc) + plane_read(ch, r1, c1) * (fr * fc);
    return SAMPLE_W'(acc >>> (2 * FRAC_W));
  endfunction

  task automatic report_mismatch(string what, logic signed [SAMPLE_W-1:0] got,
                                 logic signed [SAMPLE_W-1:0] want);
    $display("%0t pixel check: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      rows_reg <= DIM_RESET;
      cols_reg <= DIM_RESET;
      pixel_queue.delete();
      queued <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_queue.size() == 0) begin
          report_mismatch("pixel word with none pending", out_pixel, '0);
        end else begin
          want = pixel_queue.pop_front();
          if (out_pixel !== want) report_mismatch("pixel value", out_pixel, want);
        end
      end
      if (in_valid && !in_stall) begin
        if (in_mode == MODE_LOAD) begin
          if (int'(in_channel) < MAX_CHANNELS && int'(in_row) < MAX_SOURCE_DIM &&
              int'(in_col) < MAX_SOURCE_DIM)
            plane_mem[(int'(in_channel) * MAX_SOURCE_DIM + int'(in_row)) * MAX_SOURCE_DIM
                      + int'(in_col)] = in_sample;
        end else begin
          pixel_queue.push_back(blend_pixel(int'(in_channel), int'(in_row), int'(in_col)));
        end
      end
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_SOURCE_HEIGHT: rows_reg <= cfg_data;
          CFG_SOURCE_WIDTH:  cols_reg <= cfg_data;
          default: ;
        endcase
      end
      queued <= pixel_queue.size();
    end
  end

endmodule

// File: tb/bilinear_grid_upsampler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_grid_upsampler_unit_tb
// Drives source loads and pixel requests into the upsampler under a series
// of source sizes, with random gaps on both channels; the checker predicts
// and compares every pixel.
// ----------------------------------------------------------------------------
module bilinear_grid_upsampler_unit_tb;
  import bgu_pkg::*;

  localparam int OUT_H       = 40;
  localparam int OUT_W       = 40;
  localparam int NUM_CH      = 8;
  localparam int SRC_DIM     = 64;
  localparam int DIM_CAP     = (SRC_DIM < 64) ? SRC_DIM : 64;
  localparam int SETTLE      = 20;
  localparam int RUN_LIMIT   = 200000;
  localparam int PHASE_WORDS = 65;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_mode = MODE_LOAD;
  logic        [CH_W-1:0]        in_channel = '0;
  logic        [IDX_W-1:0]       in_row = '0;
  logic        [IDX_W-1:0]       in_col = '0;
  logic signed [SAMPLE_W-1:0]    in_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]    out_pixel;
  logic                          cfg_write_en = 1'b0;
  logic        [CFG_IDX_W-1:0]   cfg_index = CFG_SOURCE_HEIGHT;
  logic        [DIM_REG_W-1:0]   cfg_data = '0;

  int error_count;
  int pending_results;
  int cycle_count = 0;
  int words_sent = 0;
  int stall_left = 0;
  bit burst_send = 1'b0;
  bit burst_take = 1'b0;
  int rows_eff = DIM_RESET;
  int cols_eff = DIM_RESET;
  bit written_map [NUM_CH * SRC_DIM * SRC_DIM];
  int phase_h [10] = '{1, 64, 0, 5, 2, 127, 7, 64, 13, 20};
  int phase_w [10] = '{1, 64, 127, 3, 64, 0, 11, 2, 40, 20};

  bilinear_grid_upsampler_unit #(
    .OUT_HEIGHT(OUT_H), .OUT_WIDTH(OUT_W), .MAX_CHANNELS(NUM_CH), .MAX_SOURCE_DIM(SRC_DIM)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode), .in_channel(in_channel),
    .in_row(in_row), .in_col(in_col), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel(out_pixel),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bgu_checker #(
    .OUT_HEIGHT(OUT_H), .OUT_WIDTH(OUT_W), .MAX_CHANNELS(NUM_CH), .MAX_SOURCE_DIM(SRC_DIM)
  ) pixel_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode), .in_channel(in_channel),
    .in_row(in_row), .in_col(in_col), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel(out_pixel),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .pending_results(pending_results)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("[bilinear_grid_upsampler_unit] ERROR");
      $finish;
    end
  end

  // After each pixel word that is taken, the result side draws a random stall, none in burst mode.
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      n = burst_take ? 0 : $urandom_range(0, 4);
      stall_left <= n;
      out_stall <= (n != 0);
    end else if (out_valid && stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  function automatic int eff_dim(int v);
    if (v == 0) return 1;
    if (v > DIM_CAP) return DIM_CAP;
    return v;
  endfunction

  function automatic void src_span(input int idx, input int out_n, input int size,
                                   output int lo, output int hi);
    if (idx > out_n - 1) idx = out_n - 1;
    lo = idx * (size - 1) / (out_n - 1);
    hi = (lo + 1 < size) ? lo + 1 : size - 1;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_word(logic mode, int ch, int r, int c, logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = burst_send ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_channel <= CH_W'(ch);
    in_row     <= IDX_W'(r);
    in_col     <= IDX_W'(c);
    in_sample  <= s;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic store_sample(int ch, int r, int c, logic signed [SAMPLE_W-1:0] s);
    send_word(MODE_LOAD, ch, r, c, s);
    written_map[(ch * SRC_DIM + r) * SRC_DIM + c] = 1'b1;
  endtask

  // Any source sample that the blend will read is loaded first.
  task automatic request_pixel(int ch, int r, int c);
    int r0, r1, c0, c1, rr, cc;
    src_span(r, OUT_H, rows_eff, r0, r1);
    src_span(c, OUT_W, cols_eff, c0, c1);
    for (int k = 0; k < 4; k++) begin
      rr = k[1] ? r1 : r0;
      cc = k[0] ? c1 : c0;
      if (!written_map[(ch * SRC_DIM + rr) * SRC_DIM + cc])
        store_sample(ch, rr, cc, rand_sample());
    end
    send_word(MODE_COMPUTE, ch, r, c, rand_sample());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= DIM_REG_W'(value);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int target, pick, ch, r, c;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    store_sample(0, 0, 0, SAMPLE_MAX);
    store_sample(0, 0, 1, SAMPLE_MIN);
    store_sample(0, 1, 0, SAMPLE_MIN);
    store_sample(0, 1, 1, SAMPLE_MAX);
    store_sample(0, 19, 19, SAMPLE_MAX);
    store_sample(0, 19, 18, SAMPLE_MIN);
    store_sample(0, 18, 19, SAMPLE_MIN);
    store_sample(0, 18, 18, '1);
    request_pixel(0, 0, 0);
    request_pixel(0, 1, 1);
    request_pixel(0, 39, 39);
    request_pixel(0, 63, 63);
    request_pixel(0, 38, 38);
    request_pixel(0, 40, 0);
    request_pixel(7, 0, 63);
    store_sample(0, 0, 0, '0);
    request_pixel(0, 0, 0);

    for (int p = 0; p < 10; p++) begin
      drain();
      write_reg(CFG_SOURCE_HEIGHT, phase_h[p]);
      write_reg(CFG_SOURCE_WIDTH, phase_w[p]);
      if (p % 3 == 0) begin
        write_reg(CFG_SPARE_LO, $urandom_range(0, 127));
        write_reg(CFG_SPARE_HI, $urandom_range(0, 127));
      end
      rows_eff = eff_dim(phase_h[p]);
      cols_eff = eff_dim(phase_w[p]);
      burst_send = ($urandom_range(0, 3) == 0);
      burst_take = ($urandom_range(0, 3) == 0);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        pick = $urandom_range(0, 99);
        ch = $urandom_range(0, NUM_CH - 1);
        if (pick < 2) begin
          drain();
        end else if (pick < 55) begin
          r = ($urandom_range(0, 7) == 0) ? $urandom_range(OUT_H, 63) : $urandom_range(0, OUT_H - 1);
          c = ($urandom_range(0, 7) == 0) ? $urandom_range(OUT_W, 63) : $urandom_range(0, OUT_W - 1);
          request_pixel(ch, r, c);
        end else if (pick < 88) begin
          store_sample(ch, $urandom_range(0, rows_eff - 1), $urandom_range(0, cols_eff - 1),
                       rand_sample());
        end else begin
          store_sample(ch, $urandom_range(0, SRC_DIM - 1), $urandom_range(0, SRC_DIM - 1),
                       rand_sample());
        end
      end
    end

    burst_take = 1'b0;
    drain();
    if (error_count == 0) begin
      $display("[bilinear_grid_upsampler_unit] OK");
    end else begin
      $display("[bilinear_grid_upsampler_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bgu_pkg.sv
rtl/bgu_ram.sv
rtl/bgu_axis_map.sv
rtl/bgu_blend.sv
rtl/bilinear_grid_upsampler_unit.sv
tb/bgu_checker.sv
tb/bilinear_grid_upsampler_unit_tb.sv
